FILE: rtl/dtti_pkg.sv
// Shared types, character codes and limits for the decimal text to int128 parser.
`default_nettype none

package dtti_pkg;

    localparam int CHAR_W = 8;
    localparam int VAL_W  = 128;
    localparam int HALF_W = 64;
    localparam int PROD_W = VAL_W + 3;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

    // Magnitude limits: 2^127-1 for positive, 2^127 for negative
    localparam logic [VAL_W-1:0] LIM_POS = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] LIM_NEG = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_SIGN,
        PH_DIGIT,
        PH_TAIL
    } t_phase;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              has_char;
        logic              last;
        logic              mode;
    } t_item;

    typedef struct packed {
        logic [VAL_W-1:0] mag;
        logic             neg;
        logic             seen_digit;
        logic             overflowed;
        logic             junk_seen;
        logic             mode;
    } t_fin;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/decimal_text_to_int128.sv
// Top level: streaming decimal text to signed 128-bit integer, one character per transfer.
//
//  channel | direction | tdata                              | tuser               | tlast
//  s       | in        | [7:0] char_code                    | [0] has_char [1] mode | last
//  m       | out       | [63:0] value_high [127:64] value_low | [0] valid_res     | -
//
// One character per cycle unless a last stalls; the multiply-by-ten loop is combinational.
// After the input register, a string's result passes the fin and output registers.
// Reset is synchronous, active low; it clears the scanner and empties all stages.
// A stalled m side holds the result; characters keep flowing until a last finds both
// result registers full.
`default_nettype none

module decimal_text_to_int128 (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [7:0]   i_s_tdata,   // [7:0] char_code
    input  wire  [1:0]   i_s_tuser,   // [0] has_char, [1] mode
    input  wire          i_s_tlast,
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [127:0] o_m_tdata,   // [63:0] value_high, [127:64] value_low
    output logic         o_m_tuser    // [0] valid_res
);

    logic                        r_in_valid;
    dtti_pkg::t_item             r_in;
    logic                        item_ready;
    logic                        fin_valid, fin_ready;
    dtti_pkg::t_fin              fin;
    logic [dtti_pkg::VAL_W-1:0]  value;

    assign o_s_tready = !r_in_valid || item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.char_code <= i_s_tdata;
            r_in.has_char  <= i_s_tuser[0];
            r_in.last      <= i_s_tlast;
            r_in.mode      <= i_s_tuser[1];
        end
    end

    dtti_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_in_valid),
        .i_item       (r_in),
        .o_item_ready (item_ready),
        .o_fin_valid  (fin_valid),
        .o_fin        (fin),
        .i_fin_ready  (fin_ready)
    );

    dtti_sign u_sign (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (fin_valid),
        .i_fin       (fin),
        .o_fin_ready (fin_ready),
        .o_valid     (o_m_tvalid),
        .o_value     (value),
        .o_valid_res (o_m_tuser),
        .i_ready     (i_m_tready)
    );

    assign o_m_tdata = {value[dtti_pkg::HALF_W-1:0], value[dtti_pkg::VAL_W-1:dtti_pkg::HALF_W]};

endmodule

`default_nettype wire

FILE: rtl/dtti_parse.sv
// Character scanner: phase tracking, sign, saturating accumulate by ten, end-of-string capture.
`default_nettype none

module dtti_parse (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_item_valid,
    input  wire dtti_pkg::t_item     i_item,
    output logic                     o_item_ready,
    output logic                     o_fin_valid,
    output dtti_pkg::t_fin           o_fin,
    input  wire                      i_fin_ready
);

    dtti_pkg::t_phase                r_phase, n_phase;
    logic                            r_neg, n_neg;
    logic [dtti_pkg::VAL_W-1:0]      r_acc, n_acc;
    logic                            r_seen, n_seen;
    logic                            r_ovf, n_ovf;
    logic                            r_junk, n_junk;
    logic                            r_mode, n_mode;
    logic                            r_started;
    logic                            r_fin_valid;
    dtti_pkg::t_fin                  r_fin;

    logic                            sp, dg, take_dg, prod_ovf, fin_free, take, finish;
    logic [3:0]                      digit;
    logic [dtti_pkg::PROD_W-1:0]     acc_ext, prod;

    assign fin_free     = !r_fin_valid || i_fin_ready;
    assign o_item_ready = !i_item.last || fin_free;
    assign take         = i_item_valid && o_item_ready;
    assign finish       = take && i_item.last;

    assign sp      = dtti_pkg::is_space(i_item.char_code);
    assign dg      = dtti_pkg::is_digit(i_item.char_code);
    assign digit   = i_item.char_code[3:0];
    assign acc_ext = {3'b000, r_acc};
    // acc * 10 + d as acc*8 + acc*2 + d
    assign prod    = (acc_ext << 3) + (acc_ext << 1)
                   + {{(dtti_pkg::PROD_W-4){1'b0}}, digit};

    always_comb begin
        if (r_neg) begin
            prod_ovf = (|prod[dtti_pkg::PROD_W-1:dtti_pkg::VAL_W])
                     || (prod[dtti_pkg::VAL_W-1] && (|prod[dtti_pkg::VAL_W-2:0]));
        end else begin
            prod_ovf = |prod[dtti_pkg::PROD_W-1:dtti_pkg::VAL_W-1];
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_seen  = r_seen;
        n_ovf   = r_ovf;
        n_junk  = r_junk;
        n_mode  = r_started ? r_mode : i_item.mode;
        take_dg = 1'b0;
        if (i_item.has_char) begin
            unique case (r_phase)
                dtti_pkg::PH_LEAD: begin
                    if (sp) begin
                        n_phase = dtti_pkg::PH_LEAD;
                    end else if (i_item.char_code == dtti_pkg::CHAR_PLUS
                              || i_item.char_code == dtti_pkg::CHAR_MINUS) begin
                        n_neg   = (i_item.char_code == dtti_pkg::CHAR_MINUS);
                        n_phase = dtti_pkg::PH_SIGN;
                    end else if (dg) begin
                        take_dg = 1'b1;
                        n_phase = dtti_pkg::PH_DIGIT;
                    end else begin
                        n_junk  = 1'b1;
                        n_phase = dtti_pkg::PH_TAIL;
                    end
                end
                dtti_pkg::PH_SIGN, dtti_pkg::PH_DIGIT: begin
                    if (dg) begin
                        take_dg = 1'b1;
                        n_phase = dtti_pkg::PH_DIGIT;
                    end else begin
                        if (!sp) n_junk = 1'b1;
                        n_phase = dtti_pkg::PH_TAIL;
                    end
                end
                dtti_pkg::PH_TAIL: begin
                    if (!sp) n_junk = 1'b1;
                end
            endcase
        end
        if (take_dg) begin
            n_seen = 1'b1;
            if (prod_ovf) begin
                // clamp to the limit for the current sign
                n_ovf = 1'b1;
                n_acc = r_neg ? dtti_pkg::LIM_NEG : dtti_pkg::LIM_POS;
            end else begin
                n_acc = prod[dtti_pkg::VAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= dtti_pkg::PH_LEAD;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_seen      <= 1'b0;
            r_ovf       <= 1'b0;
            r_junk      <= 1'b0;
            r_mode      <= 1'b0;
            r_started   <= 1'b0;
            r_fin_valid <= 1'b0;
        end else begin
            if (take) begin
                if (i_item.last) begin
                    // string done: start over
                    r_phase   <= dtti_pkg::PH_LEAD;
                    r_neg     <= 1'b0;
                    r_acc     <= '0;
                    r_seen    <= 1'b0;
                    r_ovf     <= 1'b0;
                    r_junk    <= 1'b0;
                    r_mode    <= 1'b0;
                    r_started <= 1'b0;
                end else begin
                    r_phase   <= n_phase;
                    r_neg     <= n_neg;
                    r_acc     <= n_acc;
                    r_seen    <= n_seen;
                    r_ovf     <= n_ovf;
                    r_junk    <= n_junk;
                    r_mode    <= n_mode;
                    r_started <= 1'b1;
                end
            end
            if (fin_free) r_fin_valid <= finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_free && finish) begin
            r_fin.mag        <= n_acc;
            r_fin.neg        <= n_neg;
            r_fin.seen_digit <= n_seen;
            r_fin.overflowed <= n_ovf;
            r_fin.junk_seen  <= n_junk;
            r_fin.mode       <= n_mode;
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_phase == dtti_pkg::PH_LEAD && !r_started && r_acc == '0 && !r_neg))
        else $error("scanner state not cleared after end of string");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_neg |-> !r_acc[dtti_pkg::VAL_W-1])
        else $error("positive magnitude above 2^127-1");

    a_neg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc[dtti_pkg::VAL_W-1] |-> (r_acc[dtti_pkg::VAL_W-2:0] == '0))
        else $error("magnitude above 2^127");

    a_lead_no_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dtti_pkg::PH_LEAD || r_phase == dtti_pkg::PH_SIGN)
        |-> (!r_seen && r_acc == '0))
        else $error("digits recorded before the digit run");

endmodule

`default_nettype wire

FILE: rtl/dtti_sign.sv
// Result stage: validity decision, two's complement negate, output register.
`default_nettype none

module dtti_sign (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_fin_valid,
    input  wire dtti_pkg::t_fin         i_fin,
    output logic                        o_fin_ready,
    output logic                        o_valid,
    output logic [dtti_pkg::VAL_W-1:0]  o_value,
    output logic                        o_valid_res,
    input  wire                         i_ready
);

    logic                        r_out_valid;
    logic [dtti_pkg::VAL_W-1:0]  r_value, n_value;
    logic                        r_valid_res, n_valid_res;

    assign o_fin_ready = !r_out_valid || i_ready;

    always_comb begin
        n_valid_res = i_fin.mode ? (i_fin.seen_digit && !i_fin.overflowed && !i_fin.junk_seen)
                                 : 1'b1;
        if (n_valid_res && i_fin.seen_digit) begin
            n_value = i_fin.neg ? (~i_fin.mag + 1'b1) : i_fin.mag;
        end else begin
            n_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_fin_ready) begin
            r_out_valid <= i_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fin_ready && i_fin_valid) begin
            r_value     <= n_value;
            r_valid_res <= n_valid_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value     = r_value;
    assign o_valid_res = r_valid_res;

endmodule

`default_nettype wire
